### sv/pgf_pkg.sv
package pgf_pkg;

   localparam int POS_W       = 32;
   localparam int MASS_W      = 56;
   localparam int ACC_W       = 48;
   localparam int G_W         = 32;
   localparam int DIFF_W      = POS_W + 1;
   localparam int MAG_W       = POS_W + 1;
   localparam int R2_W        = 2 * MAG_W;
   localparam int ROOT_W      = MAG_W + 1;
   localparam int DEN_W       = R2_W + ROOT_W;
   localparam int GM_W        = G_W + MASS_W;
   localparam int FRAC_SHIFT  = 16;
   localparam int DD_W        = MAG_W + FRAC_SHIFT;
   localparam int NUM_W       = GM_W + DD_W;
   localparam int QUO_W       = ACC_W - 1;
   localparam int MUL_CHUNK_W = 32;
   localparam int MUL_LAT     = 3;
   localparam int SQRT_LAT    = ROOT_W;
   localparam int DIV_LAT     = QUO_W + 1;

   localparam logic [QUO_W-1:0] MAG_MAX  = '1;
   localparam logic [G_W-1:0]   G_RESET  = G_W'(1);

   typedef struct packed {
      logic signed [ACC_W-1:0] first_accel_x;
      logic signed [ACC_W-1:0] first_accel_y;
      logic signed [ACC_W-1:0] first_accel_z;
      logic signed [ACC_W-1:0] second_accel_x;
      logic signed [ACC_W-1:0] second_accel_y;
      logic signed [ACC_W-1:0] second_accel_z;
      logic                    coincident;
   } rsp_type;

endpackage

### sv/pgf_mul.sv
module pgf_mul
   import pgf_pkg::*;
#(
   parameter int A_W = 32,
   parameter int B_W = 32,
   parameter int P_W = A_W + B_W
) (
   input  logic           clock,
   input  logic           en,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   output logic [P_W-1:0] p
);

   localparam int C     = MUL_CHUNK_W;
   localparam int NA    = (A_W + C - 1) / C;
   localparam int NB    = (B_W + C - 1) / C;
   localparam int AX_W  = NA * C;
   localparam int BX_W  = NB * C;
   localparam int PP_W  = 2 * C;
   localparam int ROW_W = AX_W + C;
   localparam int SUM_W = AX_W + BX_W;

   logic [AX_W-1:0]  a_ext;
   logic [BX_W-1:0]  b_ext;
   logic [PP_W-1:0]  pp_in  [NA][NB];
   logic [PP_W-1:0]  pp_ff  [NA][NB];
   logic [ROW_W-1:0] row_in [NB];
   logic [ROW_W-1:0] row_ff [NB];
   logic [SUM_W-1:0] p_in;
   logic [SUM_W-1:0] p_ff;

   assign a_ext = AX_W'(a);
   assign b_ext = BX_W'(b);

   // chunk products
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = PP_W'(a_ext[i*C +: C]) * PP_W'(b_ext[j*C +: C]);
         end
      end
   end

   // one row per chunk of b
   always_comb begin
      for (int j = 0; j < NB; j++) begin
         row_in[j] = '0;
         for (int i = 0; i < NA; i++) begin
            row_in[j] = row_in[j] + (ROW_W'(pp_ff[i][j]) << (i * C));
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int j = 0; j < NB; j++) begin
         p_in = p_in + (SUM_W'(row_ff[j]) << (j * C));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff  <= pp_in;
         row_ff <= row_in;
         p_ff   <= p_in;
      end
   end

   assign p = p_ff[P_W-1:0];

endmodule

### sv/pgf_isqrt.sv
module pgf_isqrt
   import pgf_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [R2_W-1:0]   rad,
   output logic [ROOT_W-1:0] root
);

   localparam int TW = 2 * ROOT_W + 1;

   logic [R2_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   // one result bit per stage, remainder kept as rad - root^2
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [R2_W-1:0]   rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [R2_W-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [TW-1:0]     trial;
      logic              fits;

      if (k == 0) begin : g_first
         assign rem_src  = rad;
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      always_comb begin
         trial   = (TW'(root_src) << (B + 1)) + (TW'(1) << (2 * B));
         fits    = TW'(rem_src) >= trial;
         rem_in  = fits ? R2_W'(TW'(rem_src) - trial) : rem_src;
         root_in = fits ? (root_src | (ROOT_W'(1) << B)) : root_src;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

### sv/pgf_div.sv
module pgf_div
   import pgf_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   localparam int CW = DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff [QUO_W+1];
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] q_ff   [QUO_W+1];
   logic             sat_ff [QUO_W+1];

   // first stage only checks for a quotient past the clamp
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         sat_ff[0] <= CW'(num) >= (CW'(den) << QUO_W);
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
      localparam int B = QUO_W - k;
      logic [CW-1:0]    shifted;
      logic             fits;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] q_in;

      always_comb begin
         shifted = CW'(den_ff[k-1]) << B;
         fits    = CW'(rem_ff[k-1]) >= shifted;
         rem_in  = fits ? NUM_W'(CW'(rem_ff[k-1]) - shifted) : rem_ff[k-1];
         q_in    = fits ? (q_ff[k-1] | (QUO_W'(1) << B)) : q_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            q_ff[k]   <= q_in;
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   assign quo = sat_ff[QUO_W] ? MAG_MAX : q_ff[QUO_W];

endmodule

### sv/pgf_out_buf.sv
module pgf_out_buf
   import pgf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    full,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_stall
);

   localparam logic [1:0] BUF_FULL = 2'd2;

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic       push, pop;

   assign full      = count_ff == BUF_FULL;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = head_ff;
   assign push      = in_valid && !full;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
      if (pop) begin
         head_in = tail_ff;
      end
      if (push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && pop)) begin
            head_in = in_data;
         end else begin
            tail_in = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

### sv/pairwise_gravity_force.sv
// channel   | handshake                     | payload
// ----------+-------------------------------+------------------------------------------
// req       | req_valid / req_stall         | two positions (Q24.8), two masses
// rsp       | rsp_valid / rsp_stall         | six accelerations (Q16.32), coincident
// csr       | csr_valid / csr_ready         | csr_gravity_constant (Q0.32)
//
// one body pair per cycle while the output buffer is not full; a transaction passes
// through the front stages, the 34-stage square root, a 3-stage multiplier, the
// 48-stage dividers, the output register and the output buffer
// synchronous reset clears the valid bits and the output buffer; G resets to 1
// the whole pipeline freezes only while the 2-entry output buffer is full, so one
// result may wait on rsp_stall while new pairs keep entering
module pairwise_gravity_force
   import pgf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_first_x,
   input  logic signed [POS_W-1:0]  req_first_y,
   input  logic signed [POS_W-1:0]  req_first_z,
   input  logic signed [POS_W-1:0]  req_second_x,
   input  logic signed [POS_W-1:0]  req_second_y,
   input  logic signed [POS_W-1:0]  req_second_z,
   input  logic [MASS_W-1:0]        req_first_mass,
   input  logic [MASS_W-1:0]        req_second_mass,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [ACC_W-1:0]  rsp_first_accel_x,
   output logic signed [ACC_W-1:0]  rsp_first_accel_y,
   output logic signed [ACC_W-1:0]  rsp_first_accel_z,
   output logic signed [ACC_W-1:0]  rsp_second_accel_x,
   output logic signed [ACC_W-1:0]  rsp_second_accel_y,
   output logic signed [ACC_W-1:0]  rsp_second_accel_z,
   output logic                     rsp_coincident,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [G_W-1:0]           csr_gravity_constant
);

   localparam int ST_R2   = 3;
   localparam int ST_ROOT = ST_R2 + SQRT_LAT;
   localparam int ST_DEN  = ST_ROOT + MUL_LAT;
   localparam int ST_GM   = ST_DEN - 2 * MUL_LAT;
   localparam int ST_QUO  = ST_DEN + DIV_LAT;
   localparam int ST_OUT  = ST_QUO + 1;

   localparam logic [ACC_W-1:0] ACC_MIN = ACC_W'(1) << (ACC_W - 1);

   logic                     adv, buf_full;
   logic [G_W-1:0]           gconst_ff;
   logic [ST_OUT:0]          vld_ff, vld_in;

   logic signed [POS_W-1:0]  p1_ff [3];
   logic signed [POS_W-1:0]  p2_ff [3];
   logic [MASS_W-1:0]        m1_dly_ff [ST_GM+1];
   logic [MASS_W-1:0]        m2_dly_ff [ST_GM+1];

   logic signed [DIFF_W-1:0] diff_in [3];
   logic [MAG_W-1:0]         mag_in  [3];
   logic [2:0]               neg_in;
   logic                     coin_in;

   logic [MAG_W-1:0]         mag_dly_ff  [1:ST_ROOT][3];
   logic [2:0]               neg_dly_ff  [1:ST_QUO];
   logic                     coin_dly_ff [1:ST_QUO];
   logic [R2_W-1:0]          sq_ff [3];
   logic [R2_W-1:0]          r2_dly_ff [ST_R2:ST_ROOT];

   logic [ROOT_W-1:0]        root;
   logic [DEN_W-1:0]         den;
   logic [GM_W-1:0]          gm1, gm2;
   logic [DD_W-1:0]          dd   [3];
   logic [NUM_W-1:0]         num1 [3];
   logic [NUM_W-1:0]         num2 [3];
   logic [QUO_W-1:0]         q1   [3];
   logic [QUO_W-1:0]         q2   [3];
   logic [ACC_W-1:0]         a1   [3];
   logic [ACC_W-1:0]         a2   [3];

   rsp_type                  out_ff, out_in, buf_data;

   assign csr_ready = 1'b1;
   assign adv       = !buf_full;
   assign req_stall = buf_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         gconst_ff <= G_RESET;
      end else if (csr_valid && csr_ready) begin
         gconst_ff <= csr_gravity_constant;
      end
   end

   assign vld_in = {vld_ff[ST_OUT-1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // displacement, magnitude and sign per axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = DIFF_W'(p2_ff[i]) - DIFF_W'(p1_ff[i]);
         neg_in[i]  = diff_in[i][DIFF_W-1];
         mag_in[i]  = neg_in[i] ? MAG_W'(-diff_in[i]) : MAG_W'(diff_in[i]);
      end
      coin_in = (diff_in[0] == '0) && (diff_in[1] == '0) && (diff_in[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff[0]     <= req_first_x;
         p1_ff[1]     <= req_first_y;
         p1_ff[2]     <= req_first_z;
         p2_ff[0]     <= req_second_x;
         p2_ff[1]     <= req_second_y;
         p2_ff[2]     <= req_second_z;
         m1_dly_ff[0] <= req_first_mass;
         m2_dly_ff[0] <= req_second_mass;
         for (int s = 1; s <= ST_GM; s++) begin
            m1_dly_ff[s] <= m1_dly_ff[s-1];
            m2_dly_ff[s] <= m2_dly_ff[s-1];
         end

         mag_dly_ff[1]  <= mag_in;
         neg_dly_ff[1]  <= neg_in;
         coin_dly_ff[1] <= coin_in;
         for (int s = 2; s <= ST_ROOT; s++) begin
            mag_dly_ff[s] <= mag_dly_ff[s-1];
         end
         for (int s = 2; s <= ST_QUO; s++) begin
            neg_dly_ff[s]  <= neg_dly_ff[s-1];
            coin_dly_ff[s] <= coin_dly_ff[s-1];
         end

         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= R2_W'(mag_dly_ff[1][i]) * R2_W'(mag_dly_ff[1][i]);
         end
         r2_dly_ff[ST_R2] <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         for (int s = ST_R2 + 1; s <= ST_ROOT; s++) begin
            r2_dly_ff[s] <= r2_dly_ff[s-1];
         end

         out_ff <= out_in;
      end
   end

   pgf_isqrt u_isqrt (
      .clock (clock),
      .en    (adv),
      .rad   (r2_dly_ff[ST_R2]),
      .root  (root)
   );

   // denominator r2 * r
   pgf_mul #(.A_W(R2_W), .B_W(ROOT_W), .P_W(DEN_W)) u_den_mul (
      .clock (clock),
      .en    (adv),
      .a     (r2_dly_ff[ST_ROOT]),
      .b     (root),
      .p     (den)
   );

   pgf_mul #(.A_W(G_W), .B_W(MASS_W), .P_W(GM_W)) u_gm1_mul (
      .clock (clock),
      .en    (adv),
      .a     (gconst_ff),
      .b     (m1_dly_ff[ST_GM]),
      .p     (gm1)
   );

   pgf_mul #(.A_W(G_W), .B_W(MASS_W), .P_W(GM_W)) u_gm2_mul (
      .clock (clock),
      .en    (adv),
      .a     (gconst_ff),
      .b     (m2_dly_ff[ST_GM]),
      .p     (gm2)
   );

   for (genvar i = 0; i < 3; i++) begin : g_axis
      assign dd[i] = DD_W'(mag_dly_ff[ST_ROOT][i]) << FRAC_SHIFT;

      pgf_mul #(.A_W(GM_W), .B_W(DD_W), .P_W(NUM_W)) u_num1_mul (
         .clock (clock),
         .en    (adv),
         .a     (gm2),
         .b     (dd[i]),
         .p     (num1[i])
      );

      pgf_mul #(.A_W(GM_W), .B_W(DD_W), .P_W(NUM_W)) u_num2_mul (
         .clock (clock),
         .en    (adv),
         .a     (gm1),
         .b     (dd[i]),
         .p     (num2[i])
      );

      pgf_div u_div1 (
         .clock (clock),
         .en    (adv),
         .num   (num1[i]),
         .den   (den),
         .quo   (q1[i])
      );

      pgf_div u_div2 (
         .clock (clock),
         .en    (adv),
         .num   (num2[i]),
         .den   (den),
         .quo   (q2[i])
      );
   end

   // attach signs, body two pulls the opposite way; zero out coincident pairs
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (coin_dly_ff[ST_QUO]) begin
            a1[i] = '0;
            a2[i] = '0;
         end else if (neg_dly_ff[ST_QUO][i]) begin
            a1[i] = -ACC_W'(q1[i]);
            a2[i] = ACC_W'(q2[i]);
         end else begin
            a1[i] = ACC_W'(q1[i]);
            a2[i] = -ACC_W'(q2[i]);
         end
      end
      out_in.first_accel_x  = a1[0];
      out_in.first_accel_y  = a1[1];
      out_in.first_accel_z  = a1[2];
      out_in.second_accel_x = a2[0];
      out_in.second_accel_y = a2[1];
      out_in.second_accel_z = a2[2];
      out_in.coincident     = coin_dly_ff[ST_QUO];
   end

   pgf_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[ST_OUT]),
      .in_data   (out_ff),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (buf_data),
      .out_stall (rsp_stall)
   );

   assign rsp_first_accel_x  = buf_data.first_accel_x;
   assign rsp_first_accel_y  = buf_data.first_accel_y;
   assign rsp_first_accel_z  = buf_data.first_accel_z;
   assign rsp_second_accel_x = buf_data.second_accel_x;
   assign rsp_second_accel_y = buf_data.second_accel_y;
   assign rsp_second_accel_z = buf_data.second_accel_z;
   assign rsp_coincident     = buf_data.coincident;

   a_coincident_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coincident |->
         rsp_first_accel_x == '0 && rsp_first_accel_y == '0 && rsp_first_accel_z == '0 &&
         rsp_second_accel_x == '0 && rsp_second_accel_y == '0 &&
         rsp_second_accel_z == '0)
      else $error("coincident transaction with nonzero acceleration");

   // the two bodies never both get a negative component on the same axis
   a_opposite_signs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         !(rsp_first_accel_x[ACC_W-1] && rsp_second_accel_x[ACC_W-1]) &&
         !(rsp_first_accel_y[ACC_W-1] && rsp_second_accel_y[ACC_W-1]) &&
         !(rsp_first_accel_z[ACC_W-1] && rsp_second_accel_z[ACC_W-1]))
      else $error("accelerations of the two bodies not opposite");

   a_symmetric_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_first_accel_x != ACC_MIN && rsp_first_accel_y != ACC_MIN &&
         rsp_first_accel_z != ACC_MIN)
      else $error("acceleration reached the negative limit");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
